/* rtl/pegb_pkg.sv */
package pegb_pkg;

  localparam int IDX_W      = 10;
  localparam int DATA_W     = 32;
  localparam int DT_W       = 16;
  localparam int GRAV_W     = 31;
  localparam int RAD_W      = 31;
  localparam int REST_W     = 17;
  localparam int CFG_ADDR_W = 5;
  localparam int APB_W      = 32;

  localparam int DEF_PARTICLE_COUNT = 1024;

  localparam logic [2:0] REG_TIME_STEP   = 3'd0;
  localparam logic [2:0] REG_GRAVITY     = 3'd1;
  localparam logic [2:0] REG_RADIUS      = 3'd2;
  localparam logic [2:0] REG_RESTITUTION = 3'd3;
  localparam logic [2:0] REG_GROUND      = 3'd4;

  localparam logic [DT_W-1:0]   RST_TIME_STEP   = 16'd1092;
  localparam logic [GRAV_W-1:0] RST_GRAVITY     = 31'd6554;
  localparam logic [RAD_W-1:0]  RST_RADIUS      = 31'd6554;
  localparam logic [REST_W-1:0] RST_RESTITUTION = 17'd52429;
  localparam logic [DATA_W-1:0] RST_GROUND      = 32'd0;

  typedef struct packed {
    logic [DT_W-1:0]          time_step;
    logic [GRAV_W-1:0]        gravity;
    logic [RAD_W-1:0]         radius;
    logic [REST_W-1:0]        restitution;
    logic signed [DATA_W-1:0] ground;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] acc_x;
    logic signed [DATA_W-1:0] acc_z;
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic                     hit;
  } result_t;

  function automatic int addr_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  // round to nearest, ties up
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
    return (p + 64'sd32768) >>> 16;
  endfunction

endpackage

/* rtl/pegb_cfg.sv */
module pegb_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pegb_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pegb_pkg::APB_W-1:0]         pwdata,
  output logic [pegb_pkg::APB_W-1:0]         prdata,
  output logic                               pready,
  output pegb_pkg::cfg_t                     cfg
);
  import pegb_pkg::*;

  logic [2:0] reg_sel;
  logic       wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_ADDR_W-1:2];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step   <= RST_TIME_STEP;
      cfg.gravity     <= RST_GRAVITY;
      cfg.radius      <= RST_RADIUS;
      cfg.restitution <= RST_RESTITUTION;
      cfg.ground      <= $signed(RST_GROUND);
    end else if (wr) begin
      unique case (reg_sel)
        REG_TIME_STEP:   cfg.time_step   <= pwdata[DT_W-1:0];
        REG_GRAVITY:     cfg.gravity     <= pwdata[GRAV_W-1:0];
        REG_RADIUS:      cfg.radius      <= pwdata[RAD_W-1:0];
        REG_RESTITUTION: cfg.restitution <= pwdata[REST_W-1:0];
        REG_GROUND:      cfg.ground      <= $signed(pwdata[DATA_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TIME_STEP:   prdata = APB_W'(cfg.time_step);
      REG_GRAVITY:     prdata = APB_W'(cfg.gravity);
      REG_RADIUS:      prdata = APB_W'(cfg.radius);
      REG_RESTITUTION: prdata = APB_W'(cfg.restitution);
      REG_GROUND:      prdata = cfg.ground;
      default:         prdata = '0;
    endcase
  end

endmodule

/* rtl/pegb_state_mem.sv */
module pegb_state_mem #(
  parameter int PARTICLE_COUNT = pegb_pkg::DEF_PARTICLE_COUNT,
  localparam int ADDR_W = pegb_pkg::addr_bits(PARTICLE_COUNT)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  pegb_pkg::state_t     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output pegb_pkg::state_t     rd_data
);
  import pegb_pkg::*;

  state_t mem [PARTICLE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/pegb_pipe.sv */
module pegb_pipe #(
  parameter int PARTICLE_COUNT = pegb_pkg::DEF_PARTICLE_COUNT,
  localparam int ADDR_W = pegb_pkg::addr_bits(PARTICLE_COUNT)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pegb_pkg::cfg_t                        cfg,
  input  logic                                  clearing,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [pegb_pkg::IDX_W-1:0]            particle_index,
  input  logic signed [pegb_pkg::DATA_W-1:0]    position_x,
  input  logic signed [pegb_pkg::DATA_W-1:0]    position_y,
  input  logic signed [pegb_pkg::DATA_W-1:0]    position_z,
  output logic                                  rd_en,
  output logic [ADDR_W-1:0]                     rd_addr,
  input  pegb_pkg::state_t                      rd_data,
  output logic                                  wr_en,
  output logic [ADDR_W-1:0]                     wr_addr,
  output pegb_pkg::state_t                      wr_data,
  output logic                                  res_valid,
  input  logic                                  res_take,
  output pegb_pkg::result_t                     res
);
  import pegb_pkg::*;

  // stage valids
  logic va, vm, v2, v3, v4, v5;
  logic ldm, ld2, ld3, ld4, ld5, a_load, move_a, hazard;

  // input register
  logic [IDX_W-1:0]         a_idx;
  logic [ADDR_W-1:0]        a_addr;
  logic signed [DATA_W-1:0] a_px, a_py, a_pz;

  // memory read stage
  logic [ADDR_W-1:0]        m_addr;
  logic signed [DATA_W-1:0] m_px, m_py, m_pz;

  // stage 2: acceleration products
  logic [ADDR_W-1:0]        s2_addr;
  logic signed [DATA_W-1:0] s2_px, s2_py, s2_pz, s2_vx, s2_vy, s2_vz;
  logic signed [47:0]       s2_ax, s2_ay, s2_az;

  // stage 3: new velocity
  logic [ADDR_W-1:0]        s3_addr;
  logic signed [DATA_W-1:0] s3_px, s3_py, s3_pz, s3_vx, s3_vy, s3_vz;

  // stage 4: velocity products
  logic [ADDR_W-1:0]        s4_addr;
  logic signed [DATA_W-1:0] s4_px, s4_py, s4_pz, s4_vx, s4_vy, s4_vz;
  logic signed [47:0]       s4_dx, s4_dy, s4_dz;
  logic signed [62:0]       s4_gx, s4_gz;
  logic signed [48:0]       s4_rx, s4_ry, s4_rz;

  // stage 5: rounded values
  logic [ADDR_W-1:0]        s5_addr;
  logic signed [DATA_W-1:0] s5_px, s5_py, s5_pz, s5_vx, s5_vy, s5_vz;
  logic signed [DATA_W-1:0] s5_nx, s5_nz, s5_bx, s5_by, s5_bz;

  logic [47:0]              g_dt;
  logic signed [DATA_W-1:0] vy_neg;
  logic signed [33:0]       bottom;
  logic                     hit;

  assign ld5    = !v5 || res_take;
  assign ld4    = !v4 || ld5;
  assign ld3    = !v3 || ld4;
  assign ld2    = !v2 || ld3;
  assign ldm    = !vm || ld2;
  assign hazard = (vm && m_addr == a_addr) || (v2 && s2_addr == a_addr) ||
                  (v3 && s3_addr == a_addr) || (v4 && s4_addr == a_addr) ||
                  (v5 && s5_addr == a_addr);
  assign move_a     = va && !hazard && !clearing && ldm;
  assign a_load     = !clearing && (!va || move_a);
  assign item_stall = clearing || (va && !move_a);
  assign rd_en      = move_a;
  assign rd_addr    = a_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vm <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (a_load) va <= item_valid;
      if (ldm)    vm <= move_a;
      if (ld2)    v2 <= vm;
      if (ld3)    v3 <= v2;
      if (ld4)    v4 <= v3;
      if (ld5)    v5 <= v4;
    end
  end

  // index reduction modulo the particle count
  if (PARTICLE_COUNT < (1 << IDX_W)) begin : g_reduce
    localparam int          RECIP_SH = 24;
    localparam int          REM_W    = IDX_W + 1;
    localparam logic [24:0] RECIP    = 25'((2 ** RECIP_SH) / PARTICLE_COUNT + 1);
    logic [34:0]            q_prod;
    logic [IDX_W-1:0]       a_q;
    logic [2*IDX_W-1:0]     qd;
    logic [REM_W-1:0]       rem0, rem;

    assign q_prod = 35'(particle_index) * 35'(RECIP);

    always_ff @(posedge clk) begin
      if (a_load) a_q <= q_prod[RECIP_SH +: IDX_W];
    end

    assign qd   = (2*IDX_W)'(a_q) * (2*IDX_W)'(PARTICLE_COUNT);
    assign rem0 = REM_W'(a_idx) - qd[REM_W-1:0];
    assign rem  = (rem0 >= REM_W'(PARTICLE_COUNT)) ? rem0 - REM_W'(PARTICLE_COUNT) : rem0;
    assign a_addr = ADDR_W'(rem);
  end else begin : g_direct
    assign a_addr = ADDR_W'(a_idx);
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_idx <= particle_index;
      a_px  <= position_x;
      a_py  <= position_y;
      a_pz  <= position_z;
    end
  end

  always_ff @(posedge clk) begin
    if (ldm) begin
      m_addr <= a_addr;
      m_px   <= a_px;
      m_py   <= a_py;
      m_pz   <= a_pz;
    end
  end

  assign g_dt = 48'(cfg.gravity) * 48'(cfg.time_step);

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_addr <= m_addr;
      s2_px   <= m_px;
      s2_py   <= m_py;
      s2_pz   <= m_pz;
      s2_vx   <= rd_data.vel_x;
      s2_vy   <= rd_data.vel_y;
      s2_vz   <= rd_data.vel_z;
      s2_ax   <= $signed(48'(rd_data.acc_x)) * $signed(48'(cfg.time_step));
      s2_ay   <= -$signed(g_dt);
      s2_az   <= $signed(48'(rd_data.acc_z)) * $signed(48'(cfg.time_step));
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_addr <= s2_addr;
      s3_px   <= s2_px;
      s3_py   <= s2_py;
      s3_pz   <= s2_pz;
      s3_vx   <= sat32(64'(s2_vx) + rnd16(64'(s2_ax)));
      s3_vy   <= sat32(64'(s2_vy) + rnd16(64'(s2_ay)));
      s3_vz   <= sat32(64'(s2_vz) + rnd16(64'(s2_az)));
    end
  end

  assign vy_neg = sat32(-64'(s3_vy));

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_addr <= s3_addr;
      s4_px   <= s3_px;
      s4_py   <= s3_py;
      s4_pz   <= s3_pz;
      s4_vx   <= s3_vx;
      s4_vy   <= s3_vy;
      s4_vz   <= s3_vz;
      s4_dx   <= $signed(48'(s3_vx)) * $signed(48'(cfg.time_step));
      s4_dy   <= $signed(48'(s3_vy)) * $signed(48'(cfg.time_step));
      s4_dz   <= $signed(48'(s3_vz)) * $signed(48'(cfg.time_step));
      s4_gx   <= $signed(63'(s3_vx)) * $signed(63'(cfg.gravity));
      s4_gz   <= $signed(63'(s3_vz)) * $signed(63'(cfg.gravity));
      s4_rx   <= $signed(49'(s3_vx)) * $signed(49'(cfg.restitution));
      s4_ry   <= $signed(49'(vy_neg)) * $signed(49'(cfg.restitution));
      s4_rz   <= $signed(49'(s3_vz)) * $signed(49'(cfg.restitution));
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_addr <= s4_addr;
      s5_px   <= sat32(64'(s4_px) + rnd16(64'(s4_dx)));
      s5_py   <= sat32(64'(s4_py) + rnd16(64'(s4_dy)));
      s5_pz   <= sat32(64'(s4_pz) + rnd16(64'(s4_dz)));
      s5_vx   <= s4_vx;
      s5_vy   <= s4_vy;
      s5_vz   <= s4_vz;
      s5_nx   <= sat32(-rnd16(64'(s4_gx)));
      s5_nz   <= sat32(-rnd16(64'(s4_gz)));
      s5_bx   <= sat32(rnd16(64'(s4_rx)));
      s5_by   <= sat32(rnd16(64'(s4_ry)));
      s5_bz   <= sat32(rnd16(64'(s4_rz)));
    end
  end

  // ground test and response
  assign bottom = 34'(s5_py) - $signed(34'(cfg.radius));
  assign hit    = bottom < $signed(34'(cfg.ground));

  always_comb begin
    res.pos_x = s5_px;
    res.pos_z = s5_pz;
    res.hit   = hit;
    if (hit) begin
      res.pos_y     = sat32($signed(64'(cfg.ground) + $signed(64'(cfg.radius))));
      wr_data.vel_x = s5_bx;
      wr_data.vel_y = s5_by;
      wr_data.vel_z = s5_bz;
      wr_data.acc_x = s5_nx;
      wr_data.acc_z = s5_nz;
    end else begin
      res.pos_y     = s5_py;
      wr_data.vel_x = s5_vx;
      wr_data.vel_y = s5_vy;
      wr_data.vel_z = s5_vz;
      wr_data.acc_x = '0;
      wr_data.acc_z = '0;
    end
  end

  assign res_valid = v5;
  assign wr_en     = v5 && res_take;
  assign wr_addr   = s5_addr;

endmodule

/* rtl/particle_euler_ground_bounce.sv */
// channel   | handshake                    | payload
// item      | item_valid / item_stall      | particle_index, position_x/y/z
// result    | result_valid / result_stall  | new_position_x/y/z, ground_hit
// config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One item per cycle while item_stall is low; a taken item passes through the input
// register, the memory read stage, the pipeline stages and the output register. An item
// whose particle is still in flight waits in the input register until the earlier item
// writes back its motion state. After reset the state memory is zeroed, one entry a
// cycle, with item_stall high until every entry is cleared. A stalled result holds in
// the output register while the pipeline keeps filling behind it.
module particle_euler_ground_bounce #(
  parameter int PARTICLE_COUNT = pegb_pkg::DEF_PARTICLE_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pegb_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [pegb_pkg::APB_W-1:0]            pwdata,
  output logic [pegb_pkg::APB_W-1:0]            prdata,
  output logic                                  pready,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [pegb_pkg::IDX_W-1:0]            particle_index,
  input  logic signed [pegb_pkg::DATA_W-1:0]    position_x,
  input  logic signed [pegb_pkg::DATA_W-1:0]    position_y,
  input  logic signed [pegb_pkg::DATA_W-1:0]    position_z,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [pegb_pkg::DATA_W-1:0]    new_position_x,
  output logic signed [pegb_pkg::DATA_W-1:0]    new_position_y,
  output logic signed [pegb_pkg::DATA_W-1:0]    new_position_z,
  output logic                                  ground_hit
);
  import pegb_pkg::*;

  localparam int ADDR_W = addr_bits(PARTICLE_COUNT);

  cfg_t              cfg;
  state_t            rd_data, wr_data, mem_wdata;
  result_t           res;
  logic              rd_en, wr_en, mem_we, res_valid, res_take;
  logic [ADDR_W-1:0] rd_addr, wr_addr, mem_waddr, clr_cnt;
  logic              clearing;

  pegb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == ADDR_W'(PARTICLE_COUNT - 1)) clearing <= 1'b0;
    end
  end

  assign mem_we    = clearing || wr_en;
  assign mem_waddr = clearing ? clr_cnt : wr_addr;
  assign mem_wdata = clearing ? '0 : wr_data;

  pegb_state_mem #(
    .PARTICLE_COUNT (PARTICLE_COUNT)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pegb_pipe #(
    .PARTICLE_COUNT (PARTICLE_COUNT)
  ) u_pipe (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .clearing       (clearing),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .particle_index (particle_index),
    .position_x     (position_x),
    .position_y     (position_y),
    .position_z     (position_z),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res            (res)
  );

  // output register
  assign res_take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      new_position_x <= res.pos_x;
      new_position_y <= res.pos_y;
      new_position_z <= res.pos_z;
      ground_hit     <= res.hit;
    end
  end

endmodule
